// File: rtl/assert_macros.svh
// Assertion macros shared by the complex arithmetic unit RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: rtl/cau_pkg.sv
// Package for the complex arithmetic unit: widths, opcodes, request and
// response structs, pipeline payload and the arctangent table. No dependencies.
`default_nettype none

package cau_pkg;

  localparam int DATA_WIDTH     = 32;
  localparam int FRAC_BITS      = 16;
  localparam int PROD_WIDTH     = 2 * DATA_WIDTH;
  localparam int SUM_WIDTH      = PROD_WIDTH + 1;
  localparam int SQRT_REM_WIDTH = DATA_WIDTH + 1;
  localparam int CORDIC_WIDTH   = 64;
  localparam int CORDIC_STEPS   = 31;
  localparam int CORDIC_TOP     = 59;
  localparam int ANGLE_FRAC     = 30;
  localparam int ANGLE_WIDTH    = ANGLE_FRAC + 3;
  localparam int SHIFT_WIDTH    = $clog2(CORDIC_WIDTH);
  localparam int CORE_STAGES    = DATA_WIDTH;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MAG = 3'd4,
    OP_ARG = 3'd5,
    OP_EQ  = 3'd6
  } opcode_t;

  typedef struct packed {
    logic [2:0]                   opcode;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
  } cau_req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] res_re;
    logic signed [DATA_WIDTH-1:0] res_im;
    logic                         error_code;
    logic                         is_equal;
    logic                         saturated;
  } cau_rsp_t;

  typedef struct packed {
    logic [2:0]                   opcode;
    logic                         err;
    logic                         eq;
    logic                         st;
    logic signed [DATA_WIDTH-1:0] re;
    logic signed [DATA_WIDTH-1:0] im;
  } cau_ctl_t;

  typedef struct packed {
    cau_ctl_t                       ctl;
    logic [PROD_WIDTH-1:0]          den;
    logic [PROD_WIDTH-1:0]          dre_r;
    logic [DATA_WIDTH-1:0]          dre_qn;
    logic                           dre_neg;
    logic                           dre_ovf;
    logic [PROD_WIDTH-1:0]          dim_r;
    logic [DATA_WIDTH-1:0]          dim_qn;
    logic                           dim_neg;
    logic                           dim_ovf;
    logic [PROD_WIDTH-1:0]          sq_n;
    logic [SQRT_REM_WIDTH-1:0]      sq_rem;
    logic [DATA_WIDTH-1:0]          sq_q;
    logic signed [CORDIC_WIDTH-1:0] cx;
    logic signed [CORDIC_WIDTH-1:0] cy;
    logic signed [ANGLE_WIDTH-1:0]  cz;
  } cau_core_t;

  function automatic logic [ANGLE_FRAC-1:0] atan_q30(input int idx);
    logic [ANGLE_FRAC-1:0] v;
    case (idx)
      0:  v = ANGLE_FRAC'(843314857);
      1:  v = ANGLE_FRAC'(497837829);
      2:  v = ANGLE_FRAC'(263043837);
      3:  v = ANGLE_FRAC'(133525159);
      4:  v = ANGLE_FRAC'(67021687);
      5:  v = ANGLE_FRAC'(33543516);
      6:  v = ANGLE_FRAC'(16775851);
      7:  v = ANGLE_FRAC'(8388437);
      8:  v = ANGLE_FRAC'(4194283);
      9:  v = ANGLE_FRAC'(2097149);
      default: v = (idx < CORDIC_STEPS) ? ANGLE_FRAC'(1) << (ANGLE_FRAC - 10 - (idx - 10))
                                        : '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cau_core.sv
// Iterative core of the complex arithmetic unit: per stage, one radix-2 divide
// step for each quotient part, one square-root digit and, in all but the last
// stage, one CORDIC rotation. Depends on cau_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cau_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  cau_pkg::cau_core_t   up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output cau_pkg::cau_core_t   dn_data
);
  import cau_pkg::*;

  localparam int LAST = CORE_STAGES - 1;

  cau_core_t                stg      [CORE_STAGES];
  cau_core_t                stg_next [CORE_STAGES];
  logic [CORE_STAGES-1:0]   vld;
  logic [CORE_STAGES:0]     adv;

  assign adv[CORE_STAGES] = dn_ready;
  assign up_ready         = adv[0];
  assign dn_valid         = vld[LAST];
  assign dn_data          = stg[LAST];

  for (genvar k = 0; k < CORE_STAGES; k++) begin : g_stage
    cau_core_t din;
    logic      vin;

    if (k == 0) begin : g_first
      assign din = up_data;
      assign vin = up_valid;
    end else begin : g_next
      assign din = stg[k-1];
      assign vin = vld[k-1];
    end

    assign adv[k] = !vld[k] || adv[k+1];

    always_comb begin : step
      logic [PROD_WIDTH:0]         re_s;
      logic [PROD_WIDTH:0]         im_s;
      logic                        re_ge;
      logic                        im_ge;
      logic [SQRT_REM_WIDTH+1:0]   sq_s;
      logic [SQRT_REM_WIDTH+1:0]   sq_t;
      logic                        sq_ge;
      logic signed [CORDIC_WIDTH-1:0] dx;
      logic signed [CORDIC_WIDTH-1:0] dy;
      logic signed [ANGLE_WIDTH-1:0]  da;

      stg_next[k] = din;

      re_s  = {din.dre_r, din.dre_qn[DATA_WIDTH-1]};
      re_ge = re_s >= {1'b0, din.den};
      stg_next[k].dre_r  = re_ge ? PROD_WIDTH'(re_s - {1'b0, din.den}) : PROD_WIDTH'(re_s);
      stg_next[k].dre_qn = {din.dre_qn[DATA_WIDTH-2:0], re_ge};

      im_s  = {din.dim_r, din.dim_qn[DATA_WIDTH-1]};
      im_ge = im_s >= {1'b0, din.den};
      stg_next[k].dim_r  = im_ge ? PROD_WIDTH'(im_s - {1'b0, din.den}) : PROD_WIDTH'(im_s);
      stg_next[k].dim_qn = {din.dim_qn[DATA_WIDTH-2:0], im_ge};

      if (k == 0) begin
        stg_next[k].dre_ovf = din.dre_r >= din.den;
        stg_next[k].dim_ovf = din.dim_r >= din.den;
      end

      sq_s  = {din.sq_rem, din.sq_n[PROD_WIDTH-1 -: 2]};
      sq_t  = {1'b0, din.sq_q, 2'b01};
      sq_ge = sq_s >= sq_t;
      stg_next[k].sq_rem = sq_ge ? SQRT_REM_WIDTH'(sq_s - sq_t) : SQRT_REM_WIDTH'(sq_s);
      stg_next[k].sq_q   = {din.sq_q[DATA_WIDTH-2:0], sq_ge};
      stg_next[k].sq_n   = din.sq_n << 2;

      dx = din.cy >>> k;
      dy = din.cx >>> k;
      da = ANGLE_WIDTH'(atan_q30(k));
      if (k < CORDIC_STEPS) begin
        if (!din.cy[CORDIC_WIDTH-1]) begin
          stg_next[k].cx = din.cx + dx;
          stg_next[k].cy = din.cy - dy;
          stg_next[k].cz = din.cz + da;
        end else begin
          stg_next[k].cx = din.cx - dx;
          stg_next[k].cy = din.cy + dy;
          stg_next[k].cz = din.cz - da;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv[k]) begin
        vld[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        stg[k] <= stg_next[k];
      end
    end
  end

  `ASSERT_CLK(a_core_hold, vld[LAST] && !dn_ready |=> vld[LAST] && $stable(stg[LAST]),
              "core output changed while stalled")
  `ASSERT_CLK(a_div_rem, vld[LAST] && !stg[LAST].dre_ovf && stg[LAST].den != '0 |->
              stg[LAST].dre_r < stg[LAST].den, "divider remainder not below divisor")
  `ASSERT_CLK(a_sqrt_rem, vld[LAST] |-> stg[LAST].sq_rem <= {stg[LAST].sq_q, 1'b0},
              "square root remainder above twice the root")

endmodule

`default_nettype wire

// File: rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit top level: operand decode, products and sums, result
// formatting and output register around cau_core. Depends on cau_pkg, cau_core
// and assert_macros.svh.
// Usage: drive a request (opcode and two signed fixed-point complex operands)
// with req_valid; it is taken when req_valid and req_ready are both high. The
// response (result parts, error, equality and saturation flags) leaves on
// rsp_valid and is taken when rsp_ready is high.
// Pipeline: three front stages (products, sums, operand prep), 32 core stages
// (one divide bit and one square-root digit each, and one CORDIC rotation in
// all but the last) and the output register, the same path for every opcode.
// Throughput: one request per cycle unless the receiver stalls; every stage
// holds its own valid bit. Reset clears all valid bits; payload registers keep
// no reset value. A stalled receiver holds the response; the stages behind
// it keep filling empty slots, so req_ready drops only once all stages are full.
`default_nettype none
`include "assert_macros.svh"

module complex_arithmetic_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  cau_pkg::cau_req_t  req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output cau_pkg::cau_rsp_t  rsp
);
  import cau_pkg::*;

  localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_HALF =
    ANGLE_WIDTH'(1) << (ANGLE_FRAC - 1 - FRAC_BITS);

  typedef struct packed {
    cau_ctl_t                     ctl;
    logic signed [PROD_WIDTH-1:0] p_rr;
    logic signed [PROD_WIDTH-1:0] p_ii;
    logic signed [PROD_WIDTH-1:0] p_ri;
    logic signed [PROD_WIDTH-1:0] p_ir;
    logic signed [PROD_WIDTH-1:0] p_br2;
    logic signed [PROD_WIDTH-1:0] p_bi2;
    logic signed [PROD_WIDTH-1:0] p_ar2;
    logic signed [PROD_WIDTH-1:0] p_ai2;
    logic [DATA_WIDTH-1:0]        ux;
    logic [DATA_WIDTH-1:0]        uy;
    logic                         ysgn;
  } f1_t;

  typedef struct packed {
    cau_ctl_t                    ctl;
    logic signed [SUM_WIDTH-1:0] mre;
    logic signed [SUM_WIDTH-1:0] mim;
    logic signed [SUM_WIDTH-1:0] nre;
    logic signed [SUM_WIDTH-1:0] nim;
    logic [PROD_WIDTH-1:0]       den;
    logic [PROD_WIDTH-1:0]       sq;
    logic [DATA_WIDTH-1:0]       ux;
    logic [DATA_WIDTH-1:0]       uy;
    logic                        ysgn;
    logic [SHIFT_WIDTH-1:0]      sh;
  } f2_t;

  function automatic logic [DATA_WIDTH:0] sat_sum(input logic signed [DATA_WIDTH:0] s);
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      return {1'b1, s[DATA_WIDTH] ? SAT_MIN : SAT_MAX};
    end
    return {1'b0, s[DATA_WIDTH-1:0]};
  endfunction

  function automatic logic [DATA_WIDTH:0] sat_prod(input logic signed [SUM_WIDTH-1:0] m);
    logic [SUM_WIDTH-DATA_WIDTH-FRAC_BITS:0] hi;
    hi = m[SUM_WIDTH-1 : DATA_WIDTH-1+FRAC_BITS];
    if (!(&hi) && |hi) begin
      return {1'b1, m[SUM_WIDTH-1] ? SAT_MIN : SAT_MAX};
    end
    return {1'b0, m[DATA_WIDTH-1+FRAC_BITS : FRAC_BITS]};
  endfunction

  function automatic logic [DATA_WIDTH:0] div_fin(input logic [DATA_WIDTH-1:0] q,
                                                  input logic neg, input logic ovf);
    logic [DATA_WIDTH-1:0] lim;
    lim = neg ? SAT_MIN : SAT_MAX;
    if (ovf || q > lim) begin
      return {1'b1, neg ? SAT_MIN : SAT_MAX};
    end
    return {1'b0, neg ? DATA_WIDTH'(-q) : q};
  endfunction

  function automatic logic [DATA_WIDTH-1:0] mag(input logic signed [DATA_WIDTH-1:0] v);
    return v[DATA_WIDTH-1] ? DATA_WIDTH'(-v) : v;
  endfunction

  function automatic logic [SHIFT_WIDTH-1:0] msb_pos(input logic [DATA_WIDTH-1:0] m);
    logic [SHIFT_WIDTH-1:0] pos;
    pos = '0;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      if (m[i]) pos = SHIFT_WIDTH'(i);
    end
    return pos;
  endfunction

  f1_t        f1, f1_next;
  f2_t        f2, f2_next;
  cau_core_t  f3, f3_next;
  logic       v1, v2, v3;
  logic       adv1, adv2, adv3, adv_out;
  logic       core_ready;
  logic       core_valid;
  cau_core_t  core_out;
  cau_rsp_t   rsp_next;

  assign adv_out   = !rsp_valid || rsp_ready;
  assign adv3      = !v3 || core_ready;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign req_ready = adv1;

  always_comb begin : front1
    logic signed [DATA_WIDTH:0] s_re;
    logic signed [DATA_WIDTH:0] s_im;
    logic [DATA_WIDTH:0]        r_re;
    logic [DATA_WIDTH:0]        r_im;

    f1_next.p_rr  = req.a_re * req.b_re;
    f1_next.p_ii  = req.a_im * req.b_im;
    f1_next.p_ri  = req.a_re * req.b_im;
    f1_next.p_ir  = req.a_im * req.b_re;
    f1_next.p_br2 = req.b_re * req.b_re;
    f1_next.p_bi2 = req.b_im * req.b_im;
    f1_next.p_ar2 = req.a_re * req.a_re;
    f1_next.p_ai2 = req.a_im * req.a_im;
    f1_next.ux    = mag(req.a_re);
    f1_next.uy    = mag(req.a_im);
    f1_next.ysgn  = req.a_re[DATA_WIDTH-1] ? (!req.a_im[DATA_WIDTH-1] && req.a_im != '0)
                                           : req.a_im[DATA_WIDTH-1];

    if (req.opcode == OP_SUB) begin
      s_re = (DATA_WIDTH+1)'(req.a_re) - (DATA_WIDTH+1)'(req.b_re);
      s_im = (DATA_WIDTH+1)'(req.a_im) - (DATA_WIDTH+1)'(req.b_im);
    end else begin
      s_re = (DATA_WIDTH+1)'(req.a_re) + (DATA_WIDTH+1)'(req.b_re);
      s_im = (DATA_WIDTH+1)'(req.a_im) + (DATA_WIDTH+1)'(req.b_im);
    end
    r_re = sat_sum(s_re);
    r_im = sat_sum(s_im);

    f1_next.ctl        = '0;
    f1_next.ctl.opcode = req.opcode;
    case (req.opcode)
      OP_ADD, OP_SUB: begin
        f1_next.ctl.re = r_re[DATA_WIDTH-1:0];
        f1_next.ctl.im = r_im[DATA_WIDTH-1:0];
        f1_next.ctl.st = r_re[DATA_WIDTH] | r_im[DATA_WIDTH];
      end
      OP_DIV: f1_next.ctl.err = req.b_re == '0 && req.b_im == '0;
      OP_ARG: f1_next.ctl.err = req.a_re == '0;
      OP_EQ:  f1_next.ctl.eq  = req.a_re == req.b_re && req.a_im == req.b_im;
      default: ;
    endcase
  end

  always_comb begin : front2
    logic [DATA_WIDTH-1:0] m;
    f2_next.ctl  = f1.ctl;
    f2_next.mre  = SUM_WIDTH'(f1.p_rr) - SUM_WIDTH'(f1.p_ii);
    f2_next.mim  = SUM_WIDTH'(f1.p_ri) + SUM_WIDTH'(f1.p_ir);
    f2_next.nre  = SUM_WIDTH'(f1.p_rr) + SUM_WIDTH'(f1.p_ii);
    f2_next.nim  = SUM_WIDTH'(f1.p_ir) - SUM_WIDTH'(f1.p_ri);
    f2_next.den  = f1.p_br2 + f1.p_bi2;
    f2_next.sq   = f1.p_ar2 + f1.p_ai2;
    f2_next.ux   = f1.ux;
    f2_next.uy   = f1.uy;
    f2_next.ysgn = f1.ysgn;
    m            = (f1.ux > f1.uy) ? f1.ux : f1.uy;
    f2_next.sh   = SHIFT_WIDTH'(CORDIC_TOP) - msb_pos(m);
  end

  always_comb begin : front3
    logic [SUM_WIDTH-1:0]    a_re;
    logic [SUM_WIDTH-1:0]    a_im;
    logic [DATA_WIDTH:0]     m_re;
    logic [DATA_WIDTH:0]     m_im;
    logic [CORDIC_WIDTH-1:0] xs;
    logic [CORDIC_WIDTH-1:0] ys;

    f3_next     = '0;
    f3_next.ctl = f2.ctl;
    m_re = sat_prod(f2.mre);
    m_im = sat_prod(f2.mim);
    if (f2.ctl.opcode == OP_MUL) begin
      f3_next.ctl.re = m_re[DATA_WIDTH-1:0];
      f3_next.ctl.im = m_im[DATA_WIDTH-1:0];
      f3_next.ctl.st = m_re[DATA_WIDTH] | m_im[DATA_WIDTH];
    end

    a_re = f2.nre[SUM_WIDTH-1] ? SUM_WIDTH'(-f2.nre) : f2.nre;
    a_im = f2.nim[SUM_WIDTH-1] ? SUM_WIDTH'(-f2.nim) : f2.nim;
    f3_next.den     = f2.den;
    f3_next.dre_neg = f2.nre[SUM_WIDTH-1];
    f3_next.dim_neg = f2.nim[SUM_WIDTH-1];
    f3_next.dre_r   = PROD_WIDTH'(a_re[PROD_WIDTH-1 : DATA_WIDTH-FRAC_BITS]);
    f3_next.dim_r   = PROD_WIDTH'(a_im[PROD_WIDTH-1 : DATA_WIDTH-FRAC_BITS]);
    f3_next.dre_qn  = {a_re[DATA_WIDTH-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    f3_next.dim_qn  = {a_im[DATA_WIDTH-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};

    f3_next.sq_n = f2.sq;

    xs = CORDIC_WIDTH'(f2.ux) << f2.sh;
    ys = CORDIC_WIDTH'(f2.uy) << f2.sh;
    f3_next.cx = xs;
    f3_next.cy = f2.ysgn ? CORDIC_WIDTH'(-ys) : ys;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= req_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) f1 <= f1_next;
    if (adv2) f2 <= f2_next;
    if (adv3) f3 <= f3_next;
  end

  cau_core u_core (
    .clk      (clk),
    .rst      (rst),
    .up_valid (v3),
    .up_ready (core_ready),
    .up_data  (f3),
    .dn_valid (core_valid),
    .dn_ready (adv_out),
    .dn_data  (core_out)
  );

  always_comb begin : finish
    logic [DATA_WIDTH:0]           q_re;
    logic [DATA_WIDTH:0]           q_im;
    logic signed [ANGLE_WIDTH-1:0] zr;

    q_re = div_fin(core_out.dre_qn, core_out.dre_neg, core_out.dre_ovf);
    q_im = div_fin(core_out.dim_qn, core_out.dim_neg, core_out.dim_ovf);
    zr   = (core_out.cz + ANGLE_HALF) >>> (ANGLE_FRAC - FRAC_BITS);

    rsp_next.res_re     = core_out.ctl.re;
    rsp_next.res_im     = core_out.ctl.im;
    rsp_next.error_code = core_out.ctl.err;
    rsp_next.is_equal   = core_out.ctl.eq;
    rsp_next.saturated  = core_out.ctl.st;
    case (core_out.ctl.opcode)
      OP_DIV: begin
        if (!core_out.ctl.err) begin
          rsp_next.res_re    = q_re[DATA_WIDTH-1:0];
          rsp_next.res_im    = q_im[DATA_WIDTH-1:0];
          rsp_next.saturated = q_re[DATA_WIDTH] | q_im[DATA_WIDTH];
        end
      end
      OP_MAG: begin
        rsp_next.res_re    = core_out.sq_q[DATA_WIDTH-1] ? SAT_MAX : core_out.sq_q;
        rsp_next.saturated = core_out.sq_q[DATA_WIDTH-1];
      end
      OP_ARG: begin
        if (!core_out.ctl.err) begin
          rsp_next.res_re = DATA_WIDTH'(zr);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv_out) begin
      rsp_valid <= core_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      rsp <= rsp_next;
    end
  end

  `ASSERT_CLK(a_err_zero, rsp_valid && rsp.error_code |->
              rsp.res_re == '0 && rsp.res_im == '0 && !rsp.saturated,
              "error response with nonzero result")
  `ASSERT_CLK(a_eq_only, rsp_valid && rsp.is_equal |->
              !rsp.error_code && !rsp.saturated && rsp.res_re == '0,
              "equality response carries other results")
  `ASSERT_NEVER(a_front_ready, v1 && v2 && v3 && !core_ready && req_ready,
              "request taken while front stages are full and stalled")

endmodule

`default_nettype wire

// File: tb/cau_checker.sv
// Scoreboard for the complex arithmetic unit: predicts each accepted request
// with its own fixed-point model and compares responses in order.
// Depends on cau_pkg.
module cau_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_ready,
  input  cau_pkg::cau_req_t req,
  input  logic              rsp_valid,
  input  logic              rsp_ready,
  input  cau_pkg::cau_rsp_t rsp,
  output int                fail_count,
  output int                pending,
  output int                checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam wide_t WMAX = 128'sd2147483647;
  localparam wide_t WMIN = -128'sd2147483648;
  localparam int    ARG_STEPS = 31;

  localparam logic [63:0] ATAN_Q30 [ARG_STEPS] = '{
    64'd843314857, 64'd497837829, 64'd263043837, 64'd133525159, 64'd67021687,
    64'd33543516, 64'd16775851, 64'd8388437, 64'd4194283, 64'd2097149,
    64'd1048576, 64'd524288, 64'd262144, 64'd131072, 64'd65536, 64'd32768,
    64'd16384, 64'd8192, 64'd4096, 64'd2048, 64'd1024, 64'd512, 64'd256,
    64'd128, 64'd64, 64'd32, 64'd16, 64'd8, 64'd4, 64'd2, 64'd1
  };

  cau_rsp_t expected_rsp [$];

  function automatic logic [DATA_WIDTH:0] clip(input wide_t v);
    if (v > WMAX) return {1'b1, WMAX[DATA_WIDTH-1:0]};
    if (v < WMIN) return {1'b1, WMIN[DATA_WIDTH-1:0]};
    return {1'b0, v[DATA_WIDTH-1:0]};
  endfunction

  function automatic wide_t fixed_quotient(input wide_t num, input wide_t den);
    logic [127:0] q;
    logic [127:0] mag;
    mag = (num < 0) ? -num : num;
    q = (mag << FRAC_BITS) / den;
    return (num < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic wide_t floor_sqrt(input logic [127:0] n);
    logic [127:0] r, b;
    r = 0;
    b = 128'd1 << 126;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return $signed(r);
  endfunction

  function automatic wide_t angle_of(input logic signed [63:0] re,
                                     input logic signed [63:0] im);
    logic signed [63:0] xs, ys, x, y, z, dx, dy;
    logic [63:0] ux, uy, m;
    int s;
    xs = (re < 0) ? -re : re;
    ys = (re < 0) ? -im : im;
    ux = (xs < 0) ? -xs : xs;
    uy = (ys < 0) ? -ys : ys;
    m = (ux > uy) ? ux : uy;
    s = 0;
    while (m < (64'd1 << 59)) begin
      m = m << 1;
      s++;
    end
    x = $signed(ux << s);
    y = (ys < 0) ? -$signed(uy << s) : $signed(uy << s);
    z = 0;
    for (int i = 0; i < ARG_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + $signed(ATAN_Q30[i]);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - $signed(ATAN_Q30[i]);
      end
    end
    z = (z + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    return wide_t'(z);
  endfunction

  function automatic cau_rsp_t compute_result(input cau_req_t r);
    cau_rsp_t o;
    wide_t ar, ai, br, bi, den;
    logic [DATA_WIDTH:0] cr, ci;
    ar = r.a_re;
    ai = r.a_im;
    br = r.b_re;
    bi = r.b_im;
    o = '0;
    cr = '0;
    ci = '0;
    case (r.opcode)
      OP_ADD: begin
        cr = clip(ar + br);
        ci = clip(ai + bi);
      end
      OP_SUB: begin
        cr = clip(ar - br);
        ci = clip(ai - bi);
      end
      OP_MUL: begin
        cr = clip((ar * br - ai * bi) >>> FRAC_BITS);
        ci = clip((ar * bi + ai * br) >>> FRAC_BITS);
      end
      OP_DIV: begin
        if (br == 0 && bi == 0) begin
          o.error_code = 1'b1;
        end else begin
          den = br * br + bi * bi;
          cr = clip(fixed_quotient(ar * br + ai * bi, den));
          ci = clip(fixed_quotient(ai * br - ar * bi, den));
        end
      end
      OP_MAG: cr = clip(floor_sqrt(ar * ar + ai * ai));
      OP_ARG: begin
        if (ar == 0) o.error_code = 1'b1;
        else cr = clip(angle_of(ar[63:0], ai[63:0]));
      end
      OP_EQ: o.is_equal = (ar == br && ai == bi);
      default: ;
    endcase
    o.res_re = cr[DATA_WIDTH-1:0];
    o.res_im = ci[DATA_WIDTH-1:0];
    o.saturated = cr[DATA_WIDTH] | ci[DATA_WIDTH];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    cau_rsp_t e;
    if (rst) begin
      expected_rsp.delete();
      pending = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected response", 64'(rsp.res_re), 64'(0));
        end else begin
          e = expected_rsp.pop_front();
          checked++;
          if (rsp.res_re !== e.res_re)
            report_mismatch("res_re", 64'(rsp.res_re), 64'(e.res_re));
          if (rsp.res_im !== e.res_im)
            report_mismatch("res_im", 64'(rsp.res_im), 64'(e.res_im));
          if (rsp.error_code !== e.error_code)
            report_mismatch("error_code", 64'(rsp.error_code), 64'(e.error_code));
          if (rsp.is_equal !== e.is_equal)
            report_mismatch("is_equal", 64'(rsp.is_equal), 64'(e.is_equal));
          if (rsp.saturated !== e.saturated)
            report_mismatch("saturated", 64'(rsp.saturated), 64'(e.saturated));
        end
      end
      if (req_valid && req_ready) expected_rsp.push_back(compute_result(req));
      pending = expected_rsp.size();
    end
  end

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
  end
endmodule

// File: tb/complex_arithmetic_unit_tb.sv
// Testbench top for the complex arithmetic unit: clock, reset, request and
// response drivers with idle profiles and stalls, and the verdict.
// Depends on cau_pkg, complex_arithmetic_unit and cau_checker.
module complex_arithmetic_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int LONG_STALL = 200;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  cau_req_t req;
  logic     rsp_valid;
  logic     rsp_ready;
  cau_rsp_t rsp;
  int       fail_count;
  int       pending;
  int       checked;
  int       send_idle;
  int       recv_idle;
  logic     stall_request;
  int       sent;

  complex_arithmetic_unit dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  cau_checker u_checker (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20ns * 400000);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int stall_left;
    logic stall_done;
    rsp_ready = 1'b0;
    stall_left = 0;
    stall_done = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request && !stall_done) begin
        stall_done = 1'b1;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      1: return 32'($signed($urandom_range(8)) - 4);
      2: return 32'($signed($urandom_range(32'h80000)) - 32'sh40000);
      3: return 32'($signed($urandom_range(32'h2000000)) - 32'sh1000000);
      4: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  task automatic send(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
                      input logic [31:0] br, input logic [31:0] bi);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= '{opcode: op, a_re: ar, a_im: ai, b_re: br, b_im: bi};
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_random();
    logic [2:0] op;
    logic [31:0] ar, ai, br, bi;
    op = ($urandom_range(39) == 0) ? OP_UNUSED : 3'($urandom_range(OP_EQ));
    ar = pick_operand();
    ai = pick_operand();
    br = pick_operand();
    bi = pick_operand();
    if (op == OP_EQ && $urandom_range(1)) begin
      br = ar;
      bi = $urandom_range(3) ? ai : ai ^ (32'h1 << $urandom_range(31));
    end
    send(op, ar, ai, br, bi);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    send_idle = 0;
    recv_idle = 0;
    stall_request = 1'b0;
    sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(OP_ADD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send(OP_ADD, 32'h00010000, 32'hffff0000, 32'h00008000, 32'h00000001);
    send(OP_SUB, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send(OP_SUB, 32'h00030000, 32'h0, 32'h00010000, 32'hffffffff);
    send(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send(OP_MUL, 32'h00018000, 32'hffff8000, 32'h00020000, 32'h00010000);
    send(OP_MUL, 32'hffffffff, 32'h0, 32'h00000001, 32'h0);
    send(OP_DIV, 32'h00010000, 32'h00020000, 32'h0, 32'h0);
    send(OP_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h0);
    send(OP_DIV, 32'h00030000, 32'hfffe0000, 32'h00010000, 32'h00010000);
    send(OP_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send(OP_MAG, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
    send(OP_MAG, 32'h00030000, 32'h00040000, 32'h0, 32'h0);
    send(OP_MAG, 32'h0, 32'h0, 32'h0, 32'h0);
    send(OP_ARG, 32'h0, 32'h00010000, 32'h0, 32'h0);
    send(OP_ARG, 32'h00010000, 32'h00010000, 32'h0, 32'h0);
    send(OP_ARG, 32'hffff0000, 32'h80000000, 32'h0, 32'h0);
    send(OP_ARG, 32'h80000000, 32'h0, 32'h0, 32'h0);
    send(OP_ARG, 32'h00000001, 32'h7fffffff, 32'h0, 32'h0);
    send(OP_EQ, 32'h12345678, 32'h9abcdef0, 32'h12345678, 32'h9abcdef0);
    send(OP_EQ, 32'h12345678, 32'h9abcdef0, 32'h12345678, 32'h9abcdef1);
    send(OP_UNUSED, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    drain();

    send_idle = 7;
    recv_idle = 46;
    repeat (150) send_random();
    stall_request <= 1'b1;
    repeat (150) send_random();
    drain();

    send_idle = 46;
    recv_idle = 7;
    repeat (300) send_random();
    drain();

    send_idle = 0;
    recv_idle = 0;
    repeat (300) send_random();
    drain();

    repeat (40) @(posedge clk);
    $display("covered %0d requests, %0d responses checked, three idle profiles",
             sent, checked);
    $display("with a %0d-cycle receive stall and drained pauses", LONG_STALL);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_core.sv
rtl/complex_arithmetic_unit.sv
tb/cau_checker.sv
tb/complex_arithmetic_unit_tb.sv
